// File: rtl/stencil_csr_column_generator_assert.svh
// assertion macros for the stencil csr column generator
// no dependencies; included by the top level ahead of its module declaration
`ifndef STENCIL_CSR_COLUMN_GENERATOR_ASSERT_SVH
`define STENCIL_CSR_COLUMN_GENERATOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SCCG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sccg check failed");

// next-cycle implication, disabled during reset
`define SCCG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sccg check failed");

`endif

// File: rtl/sccg_pkg.sv
// shared types, constants and the sequencer program of the stencil csr column generator
// no dependencies; imported by the top level
package sccg_pkg;

    // field and port widths
    localparam int LAT_POS_W  = 11;
    localparam int LON_POS_W  = 12;
    localparam int LEV_POS_W  = 7;
    localparam int COL_W      = 30;
    localparam int DIAG_W     = 5;
    localparam int TOTAL_W    = 35;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 72;
    localparam int M_PAD_W    = M_TDATA_W - COL_W - DIAG_W - TOTAL_W;
    localparam int LON_CFG_W  = 13;
    localparam int LAT_CFG_W  = 12;
    localparam int LEV_CFG_W  = 8;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    // parameter defaults
    localparam int DEF_MAX_LON = 4096;
    localparam int DEF_MAX_LAT = 2048;
    localparam int DEF_MAX_LEV = 128;

    // register reset values
    localparam logic [LON_CFG_W-1:0] RST_LON_COUNT = 13'd720;
    localparam logic [LAT_CFG_W-1:0] RST_LAT_COUNT = 12'd360;
    localparam logic [LEV_CFG_W-1:0] RST_LEV_COUNT = 8'd62;

    // stencil and program shape
    localparam int STENCIL_POINTS = 19;
    localparam int BASE_STEPS     = 3;
    localparam int PROG_LEN       = BASE_STEPS + STENCIL_POINTS;
    localparam int PC_W           = $clog2(PROG_LEN);
    localparam logic [DIAG_W-1:0] LAST_DIAG = DIAG_W'(STENCIL_POINTS - 1);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LON_COUNT = 2'd0,
        REG_LAT_COUNT = 2'd1,
        REG_LEV_COUNT = 2'd2
    } cfg_reg_t;

    // micro-operation kinds
    typedef enum logic [1:0] {
        OP_BASE = 2'b01,
        OP_EMIT = 2'b10
    } uop_t;

    // signed unit step along one axis
    typedef enum logic [1:0] {
        STEP_M = 2'd0,
        STEP_Z = 2'd1,
        STEP_P = 2'd2
    } step_t;

    // one control word of the sequencer program
    typedef struct packed {
        uop_t              op;
        step_t             lat_step;
        step_t             lon_step;
        step_t             lev_step;
        logic [DIAG_W-1:0] diag;
        logic              last;
    } uword_t;

    function automatic uword_t mk_word(uop_t op, step_t lat, step_t lon, step_t lev,
                                       int diag, logic last);
        uword_t w;
        w.op       = op;
        w.lat_step = lat;
        w.lon_step = lon;
        w.lev_step = lev;
        w.diag     = DIAG_W'(diag);
        w.last     = last;
        return w;
    endfunction

    // program rom: three row-base loads, then the stencil in neighbor order
    function automatic uword_t ucode(logic [PC_W-1:0] pc);
        uword_t w;
        case (pc)
            5'd0:    w = mk_word(OP_BASE, STEP_M, STEP_Z, STEP_Z, 0, 1'b0);
            5'd1:    w = mk_word(OP_BASE, STEP_Z, STEP_Z, STEP_Z, 0, 1'b0);
            5'd2:    w = mk_word(OP_BASE, STEP_P, STEP_Z, STEP_Z, 0, 1'b0);
            5'd3:    w = mk_word(OP_EMIT, STEP_M, STEP_M, STEP_Z, 0, 1'b0);
            5'd4:    w = mk_word(OP_EMIT, STEP_M, STEP_Z, STEP_M, 1, 1'b0);
            5'd5:    w = mk_word(OP_EMIT, STEP_M, STEP_Z, STEP_Z, 2, 1'b0);
            5'd6:    w = mk_word(OP_EMIT, STEP_M, STEP_Z, STEP_P, 3, 1'b0);
            5'd7:    w = mk_word(OP_EMIT, STEP_M, STEP_P, STEP_Z, 4, 1'b0);
            5'd8:    w = mk_word(OP_EMIT, STEP_Z, STEP_M, STEP_M, 5, 1'b0);
            5'd9:    w = mk_word(OP_EMIT, STEP_Z, STEP_M, STEP_Z, 6, 1'b0);
            5'd10:   w = mk_word(OP_EMIT, STEP_Z, STEP_M, STEP_P, 7, 1'b0);
            5'd11:   w = mk_word(OP_EMIT, STEP_Z, STEP_Z, STEP_M, 8, 1'b0);
            5'd12:   w = mk_word(OP_EMIT, STEP_Z, STEP_Z, STEP_Z, 9, 1'b0);
            5'd13:   w = mk_word(OP_EMIT, STEP_Z, STEP_Z, STEP_P, 10, 1'b0);
            5'd14:   w = mk_word(OP_EMIT, STEP_Z, STEP_P, STEP_M, 11, 1'b0);
            5'd15:   w = mk_word(OP_EMIT, STEP_Z, STEP_P, STEP_Z, 12, 1'b0);
            5'd16:   w = mk_word(OP_EMIT, STEP_Z, STEP_P, STEP_P, 13, 1'b0);
            5'd17:   w = mk_word(OP_EMIT, STEP_P, STEP_M, STEP_Z, 14, 1'b0);
            5'd18:   w = mk_word(OP_EMIT, STEP_P, STEP_Z, STEP_M, 15, 1'b0);
            5'd19:   w = mk_word(OP_EMIT, STEP_P, STEP_Z, STEP_Z, 16, 1'b0);
            5'd20:   w = mk_word(OP_EMIT, STEP_P, STEP_Z, STEP_P, 17, 1'b0);
            5'd21:   w = mk_word(OP_EMIT, STEP_P, STEP_P, STEP_Z, 18, 1'b1);
            default: w = mk_word(OP_BASE, STEP_Z, STEP_Z, STEP_Z, 0, 1'b1);
        endcase
        return w;
    endfunction

    // sequencer states
    typedef enum logic [1:0] {
        SEQ_IDLE = 2'b01,
        SEQ_RUN  = 2'b10
    } seq_state_t;

endpackage

// File: rtl/stencil_csr_column_generator.sv
// top level of the stencil csr column generator: sequencer, datapath and output register
// depends on sccg_pkg and stencil_csr_column_generator_assert.svh
`include "stencil_csr_column_generator_assert.svh"

// Takes one grid point per input transfer and returns the CSR column of each of the
// 19 stencil neighbors in stencil order, skipping neighbors outside the level range;
// the final result of a row (neighbor 18, flagged by m_tlast) carries the running
// non-zero count. A point is accepted only while the sequencer is idle; the sequencer
// then walks a 22-step program from a ROM, one step per cycle when not stalled: three
// steps load the row bases for the lat-1, lat and lat+1 rows through one shared
// multiplier, then one step per stencil neighbor (a skipped neighbor still spends its
// step). A stalled result channel holds the sequencer at the next in-range neighbor.
// Each result passes a multiply stage and then an output register. Configuration is
// sampled when a point is taken.
module stencil_csr_column_generator
    import sccg_pkg::*;
#(
    parameter int MAX_LON = DEF_MAX_LON,
    parameter int MAX_LAT = DEF_MAX_LAT,
    parameter int MAX_LEV = DEF_MAX_LEV
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // grid point input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // lat_pos[10:0], lon_pos[22:11], lev_pos[29:23]
    // neighbor column output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // column[29:0], diagonal[34:30],
                                             // row_end_count[69:35]
    output logic                  m_tlast    // row_last
);

    // derived widths: counts hold the maximum, indexes hold max-1
    localparam int LON_W  = $clog2(MAX_LON + 1);
    localparam int LAT_W  = $clog2(MAX_LAT + 1);
    localparam int LEV_W  = $clog2(MAX_LEV + 1);
    localparam int LONI_W = (MAX_LON > 1) ? $clog2(MAX_LON) : 1;
    localparam int LATI_W = (MAX_LAT > 1) ? $clog2(MAX_LAT) : 1;
    localparam int LEVI_W = (MAX_LEV > 1) ? $clog2(MAX_LEV) : 1;
    localparam int LIN_W  = LATI_W + LONI_W;
    localparam int PROD_W = (LIN_W + LEV_W > COL_W) ? (LIN_W + LEV_W) : COL_W;

    // configuration registers
    logic [LON_CFG_W-1:0] lon_count_reg;
    logic [LAT_CFG_W-1:0] lat_count_reg;
    logic [LEV_CFG_W-1:0] lev_count_reg;

    // sequencer and per-point registers
    seq_state_t        state_reg, state_next;
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [LATI_W-1:0] j_reg;
    logic [LONI_W-1:0] i_reg, half_reg;
    logic [LEVI_W-1:0] k_reg;
    logic [LON_W-1:0]  nlon_reg;
    logic [LEV_W-1:0]  nlev_reg;
    logic              pole_m_reg, pole_p_reg;
    logic [LIN_W-1:0]  base_m_reg, base_z_reg, base_p_reg;
    logic [TOTAL_W-1:0] total_reg;

    // multiply stage
    logic               p_valid_reg;
    logic [LIN_W-1:0]   p_lin_reg;
    logic [LEVI_W-1:0]  p_nk_reg;
    logic [DIAG_W-1:0]  p_diag_reg;
    logic               p_last_reg;
    logic [TOTAL_W-1:0] p_count_reg;

    // output register
    logic               out_valid_reg;
    logic [COL_W-1:0]   out_col_reg;
    logic [DIAG_W-1:0]  out_diag_reg;
    logic               out_last_reg;
    logic [TOTAL_W-1:0] out_total_reg;

    // input fields
    logic [LAT_POS_W-1:0] s_lat_pos;
    logic [LON_POS_W-1:0] s_lon_pos;
    logic [LEV_POS_W-1:0] s_lev_pos;
    assign s_lat_pos = s_tdata[LAT_POS_W-1:0];
    assign s_lon_pos = s_tdata[LAT_POS_W+LON_POS_W-1:LAT_POS_W];
    assign s_lev_pos = s_tdata[LAT_POS_W+LON_POS_W+LEV_POS_W-1:LAT_POS_W+LON_POS_W];

    // saturated counts and positions, sampled on acceptance
    logic [LON_W-1:0]  nlon_c;
    logic [LAT_W-1:0]  nlat_c;
    logic [LEV_W-1:0]  nlev_c;
    logic [LATI_W-1:0] j_c;
    logic [LONI_W-1:0] i_c;
    logic [LEVI_W-1:0] k_c;

    always_comb begin
        if (lon_count_reg < LON_CFG_W'(2)) begin
            nlon_c = LON_W'(2);
        end else if (32'(lon_count_reg) > 32'(MAX_LON)) begin
            nlon_c = LON_W'(MAX_LON);
        end else begin
            nlon_c = LON_W'(lon_count_reg);
        end
        if (lat_count_reg == '0) begin
            nlat_c = LAT_W'(1);
        end else if (32'(lat_count_reg) > 32'(MAX_LAT)) begin
            nlat_c = LAT_W'(MAX_LAT);
        end else begin
            nlat_c = LAT_W'(lat_count_reg);
        end
        if (lev_count_reg == '0) begin
            nlev_c = LEV_W'(1);
        end else if (32'(lev_count_reg) > 32'(MAX_LEV)) begin
            nlev_c = LEV_W'(MAX_LEV);
        end else begin
            nlev_c = LEV_W'(lev_count_reg);
        end
        if (32'(s_lat_pos) > 32'(nlat_c) - 32'd1) begin
            j_c = LATI_W'(32'(nlat_c) - 32'd1);
        end else begin
            j_c = LATI_W'(s_lat_pos);
        end
        if (32'(s_lon_pos) > 32'(nlon_c) - 32'd1) begin
            i_c = LONI_W'(32'(nlon_c) - 32'd1);
        end else begin
            i_c = LONI_W'(s_lon_pos);
        end
        if (32'(s_lev_pos) > 32'(nlev_c) - 32'd1) begin
            k_c = LEVI_W'(32'(nlev_c) - 32'd1);
        end else begin
            k_c = LEVI_W'(s_lev_pos);
        end
    end

    // handshake and flow control
    logic   s_xfer;
    logic   out_load, p_free, p_adv;
    uword_t uw;
    assign uw       = ucode(pc_reg);
    assign s_tready = (state_reg == SEQ_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign out_load = !out_valid_reg || m_tready;
    assign p_adv    = p_valid_reg && out_load;
    assign p_free   = !p_valid_reg || out_load;

    // row base multiplier: latitude row times ring length
    logic [LATI_W-1:0] nj;
    logic [LIN_W-1:0]  base_prod;
    always_comb begin
        case (uw.lat_step)
            STEP_M:  nj = pole_m_reg ? j_reg : j_reg - LATI_W'(1);
            STEP_P:  nj = pole_p_reg ? j_reg : j_reg + LATI_W'(1);
            default: nj = j_reg;
        endcase
    end
    assign base_prod = LIN_W'(nj) * LIN_W'(nlon_reg);

    // neighbor longitude with periodic wrap and pole shift
    logic [LONI_W-1:0] nlon_m1, ni_w, ni;
    logic              pole;
    assign nlon_m1 = LONI_W'(nlon_reg - LON_W'(1));
    always_comb begin
        case (uw.lon_step)
            STEP_M:  ni_w = (i_reg == '0) ? nlon_m1 : i_reg - LONI_W'(1);
            STEP_P:  ni_w = (i_reg == nlon_m1) ? '0 : i_reg + LONI_W'(1);
            default: ni_w = i_reg;
        endcase
        pole = ((uw.lat_step == STEP_M) && pole_m_reg) ||
               ((uw.lat_step == STEP_P) && pole_p_reg);
        if (!pole) begin
            ni = ni_w;
        end else if (ni_w < half_reg) begin
            ni = ni_w + half_reg;
        end else begin
            ni = ni_w - half_reg;
        end
    end

    // row base select plus longitude
    logic [LIN_W-1:0] lin;
    always_comb begin
        case (uw.lat_step)
            STEP_M:  lin = base_m_reg + LIN_W'(ni);
            STEP_P:  lin = base_p_reg + LIN_W'(ni);
            default: lin = base_z_reg + LIN_W'(ni);
        endcase
    end

    // neighbor level and range check
    logic [LEVI_W-1:0] nk;
    logic              lev_ok;
    always_comb begin
        case (uw.lev_step)
            STEP_M: begin
                lev_ok = (k_reg != '0);
                nk     = k_reg - LEVI_W'(1);
            end
            STEP_P: begin
                lev_ok = (32'(k_reg) != 32'(nlev_reg) - 32'd1);
                nk     = k_reg + LEVI_W'(1);
            end
            default: begin
                lev_ok = 1'b1;
                nk     = k_reg;
            end
        endcase
    end

    // step advance: an in-range neighbor waits for a free multiply stage
    logic running, emit, step_go, p_load;
    assign running = (state_reg == SEQ_RUN);
    assign emit    = (uw.op == OP_EMIT) && lev_ok;
    assign step_go = running && (!emit || p_free);
    assign p_load  = step_go && emit;

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        pc_next    = pc_reg;
        case (state_reg)
            SEQ_IDLE: begin
                if (s_xfer) begin
                    state_next = SEQ_RUN;
                    pc_next    = '0;
                end
            end
            SEQ_RUN: begin
                if (step_go) begin
                    if (uw.last) begin
                        state_next = SEQ_IDLE;
                        pc_next    = '0;
                    end else begin
                        pc_next = pc_reg + PC_W'(1);
                    end
                end
            end
            default: begin
                state_next = SEQ_IDLE;
                pc_next    = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= SEQ_IDLE;
            pc_reg        <= '0;
            lon_count_reg <= RST_LON_COUNT;
            lat_count_reg <= RST_LAT_COUNT;
            lev_count_reg <= RST_LEV_COUNT;
            total_reg     <= '0;
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_LON_COUNT: lon_count_reg <= cfg_wdata[LON_CFG_W-1:0];
                    REG_LAT_COUNT: lat_count_reg <= cfg_wdata[LAT_CFG_W-1:0];
                    REG_LEV_COUNT: lev_count_reg <= cfg_wdata[LEV_CFG_W-1:0];
                    default: ;
                endcase
            end
            if (p_load) begin
                total_reg <= total_reg + TOTAL_W'(1);
            end
            if (p_load) begin
                p_valid_reg <= 1'b1;
            end else if (p_adv) begin
                p_valid_reg <= 1'b0;
            end
            if (p_adv) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // point registers and row bases
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            j_reg      <= j_c;
            i_reg      <= i_c;
            k_reg      <= k_c;
            nlon_reg   <= nlon_c;
            nlev_reg   <= nlev_c;
            half_reg   <= LONI_W'(nlon_c >> 1);
            pole_m_reg <= (j_c == '0);
            pole_p_reg <= (32'(j_c) == 32'(nlat_c) - 32'd1);
        end
        if (running && (uw.op == OP_BASE)) begin
            case (uw.lat_step)
                STEP_M:  base_m_reg <= base_prod;
                STEP_P:  base_p_reg <= base_prod;
                default: base_z_reg <= base_prod;
            endcase
        end
    end

    // multiply stage load
    always_ff @(posedge aclk) begin
        if (p_load) begin
            p_lin_reg   <= lin;
            p_nk_reg    <= nk;
            p_diag_reg  <= uw.diag;
            p_last_reg  <= uw.last;
            p_count_reg <= total_reg + TOTAL_W'(1);
        end
    end

    // column = linear point times level count plus level
    logic [PROD_W-1:0] col_prod;
    assign col_prod = PROD_W'(p_lin_reg) * PROD_W'(nlev_reg) + PROD_W'(p_nk_reg);

    // output register load
    always_ff @(posedge aclk) begin
        if (p_adv) begin
            out_col_reg   <= col_prod[COL_W-1:0];
            out_diag_reg  <= p_diag_reg;
            out_last_reg  <= p_last_reg;
            out_total_reg <= p_last_reg ? p_count_reg : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_total_reg, out_diag_reg, out_col_reg};

    // the row's final result is always the last stencil neighbor
    `SCCG_ASSERT_NOW(a_last_is_final_diag, aclk, aresetn,
        m_tvalid && m_tlast, m_tdata[COL_W+DIAG_W-1:COL_W] == LAST_DIAG)
    // the running count rides only on the row's final result
    `SCCG_ASSERT_NOW(a_count_only_on_last, aclk, aresetn,
        m_tvalid && !m_tlast, m_tdata[COL_W+DIAG_W+TOTAL_W-1:COL_W+DIAG_W] == '0)
    // an accepted point starts the program at its first step
    `SCCG_ASSERT_NEXT(a_accept_starts_program, aclk, aresetn,
        s_tvalid && s_tready, (state_reg == SEQ_RUN) && (pc_reg == '0))
    // a blocked multiply stage keeps its entry
    `SCCG_ASSERT_NEXT(a_mul_stage_holds, aclk, aresetn,
        p_valid_reg && !out_load, p_valid_reg)

endmodule
